[src/sle_pkg.sv]
// sle_pkg: request and status codes, datapath command and status types
// shared by the controller, the datapath and the top level of the list engine
// no dependencies
package sle_pkg;

    localparam logic [2:0] FUNC_PUSH_BACK  = 3'd0;
    localparam logic [2:0] FUNC_PUSH_FRONT = 3'd1;
    localparam logic [2:0] FUNC_POP_FRONT  = 3'd2;
    localparam logic [2:0] FUNC_POP_BACK   = 3'd3;
    localparam logic [2:0] FUNC_FIND       = 3'd4;
    localparam logic [2:0] FUNC_INSERT     = 3'd5;
    localparam logic [2:0] FUNC_ERASE      = 3'd6;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_BADPOS   = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    typedef enum logic [2:0]
    {
        PTR_HOLD,
        PTR_TOP,
        PTR_POS1,
        PTR_ZERO,
        PTR_INC,
        PTR_DEC
    } ptr_op_t;

    typedef enum logic [2:0]
    {
        WR_NONE,
        WR_UP,
        WR_DN,
        WR_WORD_POS,
        WR_WORD_CNT
    } wr_sel_t;

    typedef struct packed
    {
        logic       load_req;
        ptr_op_t    ptr_op;
        wr_sel_t    wr_sel;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       set_status;
        logic [2:0] status_code;
        logic       set_found;
        logic       out_load;
    } dp_cmd_t;

    typedef struct packed
    {
        logic [2:0] func;
        logic       full;
        logic       empty;
        logic       pos_gt_cnt;
        logic       pos_eq_cnt;
        logic       pos_ge_cnt;
        logic       pos_is_last;
        logic       ptr_at_pos;
        logic       ptr_at_last;
        logic       match;
    } dp_stat_t;

endpackage

[src/sle_req_if.sv]
// sle_req_if: request channel of the list engine, valid/ready with payload
// no dependencies
interface sle_req_if;
    logic               valid;
    logic               ready;
    logic        [2:0]  func;
    logic        [6:0]  position;
    logic signed [31:0] value;

    modport source (output valid, output func, output position, output value, input ready);
    modport sink (input valid, input func, input position, input value, output ready);
endinterface

[src/sle_rsp_if.sv]
// sle_rsp_if: response channel of the list engine, valid/ready with payload
// no dependencies
interface sle_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [5:0] found_index;
    logic [6:0] count;

    modport source (output valid, output status, output found_index, output count, input ready);
    modport sink (input valid, input status, input found_index, input count, output ready);
endinterface

[src/sle_ram.sv]
// sle_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies
module sle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

[src/sle_datapath.sv]
// sle_datapath: element store, count, scan pointer and response registers
// depends on sle_pkg and sle_ram; driven by sle_ctrl through dp_cmd_t
module sle_datapath #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  sle_pkg::dp_cmd_t   cmd,
    output sle_pkg::dp_stat_t  stat,
    input  logic        [2:0]  func,
    input  logic        [6:0]  position,
    input  logic signed [31:0] value,
    output logic        [2:0]  status,
    output logic        [5:0]  found_index,
    output logic        [6:0]  count
);
    import sle_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > 7) ? CW : 7;

    logic [CW-1:0]         count_reg, count_next;
    logic [AW-1:0]         ptr_reg, ptr_next;
    logic [2:0]            func_reg, func_next;
    logic [6:0]            pos_reg, pos_next;
    logic [DATA_WIDTH-1:0] word_reg, word_next;
    logic [2:0]            status_reg, status_next;
    logic [AW-1:0]         found_reg, found_next;
    logic [2:0]            rsp_status_reg, rsp_status_next;
    logic [5:0]            rsp_found_reg, rsp_found_next;
    logic [6:0]            rsp_count_reg, rsp_count_next;

    logic [CW-1:0]         cnt_last;
    logic [AW-1:0]         pos_addr;
    logic [PW-1:0]         pos_ext;
    logic [PW-1:0]         cnt_ext;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [DATA_WIDTH-1:0] rd_data;

    assign cnt_last = count_reg - CW'(1);
    assign pos_addr = AW'(pos_reg);
    assign pos_ext  = PW'(pos_reg);
    assign cnt_ext  = PW'(count_reg);

    assign stat.func        = func_reg;
    assign stat.full        = (count_reg == CW'(DEPTH));
    assign stat.empty       = (count_reg == '0);
    assign stat.pos_gt_cnt  = (pos_ext > cnt_ext);
    assign stat.pos_eq_cnt  = (pos_ext == cnt_ext);
    assign stat.pos_ge_cnt  = (pos_ext >= cnt_ext);
    assign stat.pos_is_last = ((pos_ext + PW'(1)) == cnt_ext);
    assign stat.ptr_at_pos  = (ptr_reg == pos_addr);
    assign stat.ptr_at_last = (ptr_reg == cnt_last[AW-1:0]);
    assign stat.match       = (rd_data == word_reg);

    always_comb
    begin
        func_next = func_reg;
        pos_next  = pos_reg;
        word_next = word_reg;
        if (cmd.load_req)
        begin
            func_next = func;
            pos_next  = (func == FUNC_PUSH_FRONT || func == FUNC_POP_FRONT) ? '0 : position;
            word_next = DATA_WIDTH'($unsigned(value));
        end
    end

    always_comb
    begin
        unique case (cmd.ptr_op)
            PTR_HOLD: ptr_next = ptr_reg;
            PTR_TOP:  ptr_next = cnt_last[AW-1:0];
            PTR_POS1: ptr_next = pos_addr + AW'(1);
            PTR_ZERO: ptr_next = '0;
            PTR_INC:  ptr_next = ptr_reg + AW'(1);
            PTR_DEC:  ptr_next = ptr_reg - AW'(1);
            default:  ptr_next = ptr_reg;
        endcase
    end

    always_comb
    begin
        wr_en   = 1'b1;
        wr_addr = ptr_reg;
        wr_data = rd_data;
        unique case (cmd.wr_sel)
            WR_UP:
            begin
                wr_addr = ptr_reg + AW'(1);
                wr_data = rd_data;
            end
            WR_DN:
            begin
                wr_addr = ptr_reg - AW'(1);
                wr_data = rd_data;
            end
            WR_WORD_POS:
            begin
                wr_addr = pos_addr;
                wr_data = word_reg;
            end
            WR_WORD_CNT:
            begin
                wr_addr = count_reg[AW-1:0];
                wr_data = word_reg;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.cnt_inc)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.cnt_dec)
        begin
            count_next = cnt_last;
        end
    end

    always_comb
    begin
        status_next = status_reg;
        found_next  = found_reg;
        if (cmd.set_found)
        begin
            status_next = ST_OK;
            found_next  = ptr_reg;
        end
        else if (cmd.set_status)
        begin
            status_next = cmd.status_code;
            found_next  = '0;
        end
    end

    always_comb
    begin
        rsp_status_next = rsp_status_reg;
        rsp_found_next  = rsp_found_reg;
        rsp_count_next  = rsp_count_reg;
        if (cmd.out_load)
        begin
            rsp_status_next = status_reg;
            rsp_found_next  = 6'(found_reg);
            rsp_count_next  = 7'(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg        <= ptr_next;
        func_reg       <= func_next;
        pos_reg        <= pos_next;
        word_reg       <= word_next;
        status_reg     <= status_next;
        found_reg      <= found_next;
        rsp_status_reg <= rsp_status_next;
        rsp_found_reg  <= rsp_found_next;
        rsp_count_reg  <= rsp_count_next;
    end

    sle_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (ptr_next),
        .rd_data (rd_data)
    );

    assign status      = rsp_status_reg;
    assign found_index = rsp_found_reg;
    assign count       = rsp_count_reg;
endmodule

[src/sle_ctrl.sv]
// sle_ctrl: request sequencer of the list engine (decode, shift, scan, reply)
// depends on sle_pkg; drives sle_datapath through dp_cmd_t
module sle_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output sle_pkg::dp_cmd_t  cmd,
    input  sle_pkg::dp_stat_t stat
);
    import sle_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DECODE   = 3'd1;
    localparam logic [2:0] S_SHIFT_UP = 3'd2;
    localparam logic [2:0] S_PLACE    = 3'd3;
    localparam logic [2:0] S_SHIFT_DN = 3'd4;
    localparam logic [2:0] S_SCAN     = 3'd5;
    localparam logic [2:0] S_REPLY    = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       rsp_valid_reg, rsp_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.ptr_op = PTR_HOLD;
        cmd.wr_sel = WR_NONE;
        req_ready  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.set_status  = 1'b1;
                cmd.status_code = ST_OK;
                state_next      = S_REPLY;
                unique case (stat.func) inside
                    FUNC_PUSH_BACK:
                    begin
                        if (stat.full)
                        begin
                            cmd.status_code = ST_FULL;
                        end
                        else
                        begin
                            cmd.wr_sel  = WR_WORD_CNT;
                            cmd.cnt_inc = 1'b1;
                        end
                    end
                    FUNC_PUSH_FRONT, FUNC_INSERT:
                    begin
                        if (stat.pos_gt_cnt)
                        begin
                            cmd.status_code = ST_BADPOS;
                        end
                        else if (stat.full)
                        begin
                            cmd.status_code = ST_FULL;
                        end
                        else if (stat.pos_eq_cnt)
                        begin
                            cmd.wr_sel  = WR_WORD_POS;
                            cmd.cnt_inc = 1'b1;
                        end
                        else
                        begin
                            cmd.ptr_op = PTR_TOP;
                            state_next = S_SHIFT_UP;
                        end
                    end
                    FUNC_POP_FRONT, FUNC_ERASE:
                    begin
                        if (stat.empty)
                        begin
                            cmd.status_code = ST_EMPTY;
                        end
                        else if (stat.pos_ge_cnt)
                        begin
                            cmd.status_code = ST_BADPOS;
                        end
                        else if (stat.pos_is_last)
                        begin
                            cmd.cnt_dec = 1'b1;
                        end
                        else
                        begin
                            cmd.ptr_op = PTR_POS1;
                            state_next = S_SHIFT_DN;
                        end
                    end
                    FUNC_POP_BACK:
                    begin
                        if (stat.empty)
                        begin
                            cmd.status_code = ST_EMPTY;
                        end
                        else
                        begin
                            cmd.cnt_dec = 1'b1;
                        end
                    end
                    FUNC_FIND:
                    begin
                        cmd.status_code = ST_NOTFOUND;
                        if (!stat.empty)
                        begin
                            cmd.ptr_op = PTR_ZERO;
                            state_next = S_SCAN;
                        end
                    end
                    default:
                    begin
                        cmd.status_code = ST_OK;
                    end
                endcase
            end
            S_SHIFT_UP:
            begin
                cmd.wr_sel = WR_UP;
                if (stat.ptr_at_pos)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    cmd.ptr_op = PTR_DEC;
                end
            end
            S_PLACE:
            begin
                cmd.wr_sel  = WR_WORD_POS;
                cmd.cnt_inc = 1'b1;
                state_next  = S_REPLY;
            end
            S_SHIFT_DN:
            begin
                cmd.wr_sel = WR_DN;
                if (stat.ptr_at_last)
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_REPLY;
                end
                else
                begin
                    cmd.ptr_op = PTR_INC;
                end
            end
            S_SCAN:
            begin
                if (stat.match)
                begin
                    cmd.set_found = 1'b1;
                    state_next    = S_REPLY;
                end
                else if (stat.ptr_at_last)
                begin
                    state_next = S_REPLY;
                end
                else
                begin
                    cmd.ptr_op = PTR_INC;
                end
            end
            S_REPLY:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
endmodule

[src/sequential_list_engine_core.sv]
// sequential_list_engine_core: ordered list of up to DEPTH words with count
// depends on sle_pkg, sle_req_if, sle_rsp_if, sle_ctrl, sle_datapath, sle_ram
//
//   channel  dir  payload                        handshake
//   req      in   func, position, value          valid/ready
//   rsp      out  status, found_index, count     valid/ready
//
// push back, pop back, rejected and unknown requests: decode, then reply
// insert/push front: shift up from top to position, one entry moved per cycle, then place
// erase/pop front: shift down from position + 1 to the last entry, none if position is last
// find: scan from index 0 until a match or the last entry; an empty list is not scanned
// the simple dual-port element ram (one read, one write per cycle) sets the shift and scan rate
// reset empties the list at once, no clearing pass; stored words are undefined until written
// req is taken while an earlier response still waits; a stalled rsp holds the next reply
module sequential_list_engine_core #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input logic        clk,
    input logic        rst_n,
    sle_req_if.sink    req,
    sle_rsp_if.source  rsp
);
    import sle_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    sle_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    sle_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .func        (req.func),
        .position    (req.position),
        .value       (req.value),
        .status      (rsp.status),
        .found_index (rsp.found_index),
        .count       (rsp.count)
    );
endmodule
